// File: hw/rtl/wave_stencil_fd4_periodic_macros.svh
// Assertion macros for the wave stencil block.
// Used by the checker; relies on clk_i and rst_ni being visible where expanded.
`ifndef WAVE_STENCIL_FD4_PERIODIC_MACROS_SVH
`define WAVE_STENCIL_FD4_PERIODIC_MACROS_SVH

// Plain property, sampled on the rising clock edge and off while in reset.
`define WSF4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define WSF4_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/wsf4_pkg.sv
// Shared types and constants of the fourth-order wave stencil block.
// No dependencies; every other file of the block but the macro header imports it.
package wsf4_pkg;

  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned COEFF_W  = 24;
  localparam int unsigned OP_W     = 2;

  localparam int unsigned IN_TDATA_W  = ((2 * COORD_W + 2 * SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SAMPLE_W + 2 * COORD_W + 7) / 8) * 8;

  // The weighted sum of nine taps spans 128 times the sample range.
  localparam int unsigned LAP_W  = SAMPLE_W + 7;
  localparam int unsigned PROD_W = COEFF_W + 1 + LAP_W;
  // Dividing by 12 * 2^24 is a shift by 26 followed by a division by three.
  localparam int unsigned DIV_SHIFT   = 26;
  localparam int unsigned X_W         = PROD_W - 2 - DIV_SHIFT;
  localparam int unsigned RECIP3_W    = 23;
  localparam logic [RECIP3_W-1:0] RECIP3 = 23'h555556;
  localparam int unsigned RECIP3_SHIFT = 24;
  localparam int unsigned QUOT_W      = X_W - 1;
  localparam int unsigned INC_W       = QUOT_W + 1;
  localparam int unsigned SUM_W       = 24;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 18'sh1FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 18'sh20000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  // Pairs of stencil taps read together from the two ports of the current grid.
  typedef enum logic [2:0] {
    PAIR_C_W2,
    PAIR_W1_E1,
    PAIR_E2_N2,
    PAIR_N1_S1,
    PAIR_S2
  } tap_pair_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD4,
    S_ACC,
    S_MUL,
    S_DIV,
    S_WB
  } ctrl_state_e;

  typedef struct packed {
    logic      capture;
    logic      swap;
    logic      load_wr;
    logic      rd_en;
    tap_pair_e rd_pair;
    logic      mul_en;
    logic      div_en;
    logic      wb_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/wsf4_grid_ram.sv
// One grid of samples: one write port and two registered read ports.
// Depends on wsf4_pkg for the sample width.
module wsf4_grid_ram #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [wsf4_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]             raddr0_i,
  input  logic [ADDR_W-1:0]             raddr1_i,
  output logic [wsf4_pkg::SAMPLE_W-1:0] rdata0_o,
  output logic [wsf4_pkg::SAMPLE_W-1:0] rdata1_o
);
  import wsf4_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata0_q;
  logic [SAMPLE_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem[raddr0_i];
    rdata1_q <= mem[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: hw/rtl/wsf4_datapath.sv
// Datapath of the wave stencil: both grids, tap addressing, accumulation,
// scaling, saturation and the output register. Depends on wsf4_pkg, wsf4_grid_ram.
module wsf4_datapath #(
  parameter int unsigned GRID_SIZE = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [wsf4_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [wsf4_pkg::OP_W-1:0]        in_tuser_i,
  input  logic                             cfg_valid_i,
  input  logic [wsf4_pkg::COEFF_W-1:0]     cfg_data_i,
  input  wsf4_pkg::ctrl_cmd_t              cmd_i,
  output wsf4_pkg::dp_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wsf4_pkg::OUT_TDATA_W-1:0] out_tdata_o
);
  import wsf4_pkg::*;

  localparam int unsigned IDX_W      = $clog2(GRID_SIZE);
  localparam int unsigned DEPTH      = GRID_SIZE * GRID_SIZE;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned COORD_SPAN = 1 << COORD_W;
  localparam logic signed [IDX_W+1:0] GRID_S = (IDX_W + 2)'(GRID_SIZE);

  localparam logic signed [2:0] OFF_M2 = -3'sd2;
  localparam logic signed [2:0] OFF_M1 = -3'sd1;
  localparam logic signed [2:0] OFF_P1 = 3'sd1;
  localparam logic signed [2:0] OFF_P2 = 3'sd2;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic signed [2:0] offs);
    logic signed [IDX_W+1:0] s;
    s = $signed({2'b00, base}) + (IDX_W + 2)'(offs);
    if (s < 0) begin
      s = s + GRID_S;
    end else if (s >= GRID_S) begin
      s = s - GRID_S;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c);
  endfunction

  // Input unpacking.
  logic [COORD_W-1:0]  in_col;
  logic [COORD_W-1:0]  in_row;
  logic [SAMPLE_W-1:0] in_old;
  logic [SAMPLE_W-1:0] in_cur;

  assign in_col = in_tdata_i[COORD_W-1:0];
  assign in_row = in_tdata_i[2*COORD_W-1:COORD_W];
  assign in_old = in_tdata_i[2*COORD_W +: SAMPLE_W];
  assign in_cur = in_tdata_i[2*COORD_W+SAMPLE_W +: SAMPLE_W];

  // Coordinates wrap onto the grid through a table built at elaboration.
  logic [IDX_W-1:0] coord_mod [COORD_SPAN];
  for (genvar gi = 0; gi < COORD_SPAN; gi++) begin : g_mod
    assign coord_mod[gi] = IDX_W'(gi % GRID_SIZE);
  end

  logic [IDX_W-1:0]    col_q;
  logic [IDX_W-1:0]    row_q;
  logic [SAMPLE_W-1:0] load_old_q;
  logic [SAMPLE_W-1:0] load_cur_q;
  logic                cur_is_b_q;
  logic [COEFF_W-1:0]  coeff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q      <= coord_mod[in_col];
      row_q      <= coord_mod[in_row];
      load_old_q <= in_old;
      load_cur_q <= in_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_is_b_q <= 1'b0;
      coeff_q    <= '0;
    end else begin
      if (cmd_i.swap) begin
        cur_is_b_q <= ~cur_is_b_q;
      end
      if (cfg_valid_i) begin
        coeff_q <= cfg_data_i;
      end
    end
  end

  // Tap coordinates for the pair being read.
  logic [IDX_W-1:0] tap0_col;
  logic [IDX_W-1:0] tap0_row;
  logic [IDX_W-1:0] tap1_col;
  logic [IDX_W-1:0] tap1_row;

  always_comb begin
    tap0_col = col_q;
    tap0_row = row_q;
    tap1_col = col_q;
    tap1_row = row_q;
    unique case (cmd_i.rd_pair)
      PAIR_C_W2: begin
        tap1_col = wrap_idx(col_q, OFF_M2);
      end
      PAIR_W1_E1: begin
        tap0_col = wrap_idx(col_q, OFF_M1);
        tap1_col = wrap_idx(col_q, OFF_P1);
      end
      PAIR_E2_N2: begin
        tap0_col = wrap_idx(col_q, OFF_P2);
        tap1_row = wrap_idx(row_q, OFF_M2);
      end
      PAIR_N1_S1: begin
        tap0_row = wrap_idx(row_q, OFF_M1);
        tap1_row = wrap_idx(row_q, OFF_P1);
      end
      PAIR_S2: begin
        tap0_row = wrap_idx(row_q, OFF_P2);
      end
      default: begin
      end
    endcase
  end

  logic [ADDR_W-1:0] center_addr;
  logic [ADDR_W-1:0] tap0_addr;
  logic [ADDR_W-1:0] tap1_addr;

  assign center_addr = cell_addr(row_q, col_q);
  assign tap0_addr   = cell_addr(tap0_row, tap0_col);
  assign tap1_addr   = cell_addr(tap1_row, tap1_col);

  // Grid memories. The current grid serves both tap ports; the old grid
  // serves the center point on its first port.
  logic                we_a;
  logic                we_b;
  logic [SAMPLE_W-1:0] wdata_a;
  logic [SAMPLE_W-1:0] wdata_b;
  logic [ADDR_W-1:0]   raddr0_a;
  logic [ADDR_W-1:0]   raddr0_b;
  logic [SAMPLE_W-1:0] rdata0_a;
  logic [SAMPLE_W-1:0] rdata1_a;
  logic [SAMPLE_W-1:0] rdata0_b;
  logic [SAMPLE_W-1:0] rdata1_b;
  logic [SAMPLE_W-1:0] new_sat;

  assign we_a     = cmd_i.load_wr | (cmd_i.wb_en & cur_is_b_q);
  assign we_b     = cmd_i.load_wr | (cmd_i.wb_en & ~cur_is_b_q);
  assign wdata_a  = cmd_i.load_wr ? (cur_is_b_q ? load_old_q : load_cur_q) : new_sat;
  assign wdata_b  = cmd_i.load_wr ? (cur_is_b_q ? load_cur_q : load_old_q) : new_sat;
  assign raddr0_a = cur_is_b_q ? center_addr : tap0_addr;
  assign raddr0_b = cur_is_b_q ? tap0_addr : center_addr;

  wsf4_grid_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (center_addr),
    .wdata_i  (wdata_a),
    .raddr0_i (raddr0_a),
    .raddr1_i (tap1_addr),
    .rdata0_o (rdata0_a),
    .rdata1_o (rdata1_a)
  );

  wsf4_grid_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (center_addr),
    .wdata_i  (wdata_b),
    .raddr0_i (raddr0_b),
    .raddr1_i (tap1_addr),
    .rdata0_o (rdata0_b),
    .rdata1_o (rdata1_b)
  );

  logic signed [SAMPLE_W-1:0] cur_d0;
  logic signed [SAMPLE_W-1:0] cur_d1;
  logic signed [SAMPLE_W-1:0] old_d0;

  assign cur_d0 = $signed(cur_is_b_q ? rdata0_b : rdata0_a);
  assign cur_d1 = $signed(cur_is_b_q ? rdata1_b : rdata1_a);
  assign old_d0 = $signed(cur_is_b_q ? rdata0_a : rdata0_b);

  // Read data is registered and arrives in the cycle after the address, so the pair tag follows.
  logic      acc_vld_q;
  tap_pair_e acc_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_pair_q <= cmd_i.rd_pair;
  end

  logic signed [LAP_W-1:0] d0;
  logic signed [LAP_W-1:0] d1;
  logic signed [LAP_W-1:0] contrib;

  assign d0 = LAP_W'(cur_d0);
  assign d1 = LAP_W'(cur_d1);

  // The center weight -30 counts once per axis.
  always_comb begin
    unique case (acc_pair_q)
      PAIR_C_W2:              contrib = (d0 <<< 2) - (d0 <<< 6) - d1;
      PAIR_W1_E1, PAIR_N1_S1: contrib = (d0 <<< 4) + (d1 <<< 4);
      PAIR_E2_N2:             contrib = -d0 - d1;
      PAIR_S2:                contrib = -d0;
      default:                contrib = '0;
    endcase
  end

  logic signed [LAP_W-1:0]    lap_q;
  logic signed [SAMPLE_W-1:0] center_q;
  logic signed [SAMPLE_W-1:0] old_q;

  always_ff @(posedge clk_i) begin
    if (acc_vld_q) begin
      if (acc_pair_q == PAIR_C_W2) begin
        lap_q    <= contrib;
        center_q <= cur_d0;
        old_q    <= old_d0;
      end else begin
        lap_q <= lap_q + contrib;
      end
    end
  end

  // Scaling: product, then truncating division by 12 * 2^24.
  logic signed [PROD_W-1:0]    prod_d;
  logic signed [PROD_W-1:0]    prod_q;
  logic        [PROD_W-1:0]    mag;
  logic        [X_W-1:0]       x_div;
  logic [X_W+RECIP3_W-1:0]     q3;
  logic        [QUOT_W-1:0]    quot;
  logic signed [INC_W-1:0]     inc_d;
  logic signed [INC_W-1:0]     inc_q;

  assign prod_d = $signed({1'b0, coeff_q}) * lap_q;
  assign mag    = prod_q[PROD_W-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
  assign x_div  = mag[DIV_SHIFT +: X_W];
  assign q3     = (X_W + RECIP3_W)'(x_div) * (X_W + RECIP3_W)'(RECIP3);
  assign quot   = q3[RECIP3_SHIFT +: QUOT_W];
  assign inc_d  = prod_q[PROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div_en) begin
      inc_q <= inc_d;
    end
  end

  logic signed [SUM_W-1:0] sum;

  assign sum = (SUM_W'(center_q) <<< 1) - SUM_W'(old_q) + SUM_W'(inc_q);

  always_comb begin
    if (sum > SUM_W'(SAMPLE_MAX)) begin
      new_sat = SAMPLE_MAX;
    end else if (sum < SUM_W'(SAMPLE_MIN)) begin
      new_sat = SAMPLE_MIN;
    end else begin
      new_sat = sum[SAMPLE_W-1:0];
    end
  end

  // Output register: holds one result until its transfer completes.
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_value_q;
  logic [COORD_W-1:0]  out_col_q;
  logic [COORD_W-1:0]  out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      out_value_q <= new_sat;
      out_col_q   <= COORD_W'(col_q);
      out_row_q   <= COORD_W'(row_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = OUT_TDATA_W'({out_row_q, out_col_q, out_value_q});

  assign status_o.in_op    = in_tuser_i;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

endmodule

// File: hw/rtl/wsf4_ctrl.sv
// Sequencer of the wave stencil: accepts items and steps the datapath
// through load, tap reads, scaling and write-back. Depends on wsf4_pkg.
module wsf4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wsf4_pkg::dp_status_t status_i,
  output wsf4_pkg::ctrl_cmd_t  cmd_o
);
  import wsf4_pkg::*;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        // Advance and the unused code finish in the accepting cycle.
        if (in_valid_i) begin
          if (status_i.in_op == OP_LOAD) begin
            state_d = S_LOAD;
          end else if (status_i.in_op == OP_COMPUTE) begin
            state_d = S_RD0;
          end
        end
      end
      S_LOAD: state_d = S_IDLE;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_RD4;
      S_RD4:  state_d = S_ACC;
      S_ACC:  state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV:  state_d = S_WB;
      S_WB: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        cmd_o.swap    = in_valid_i && (status_i.in_op == OP_ADVANCE);
      end
      S_LOAD: cmd_o.load_wr = 1'b1;
      S_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = PAIR_C_W2;
      end
      S_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = PAIR_W1_E1;
      end
      S_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = PAIR_E2_N2;
      end
      S_RD3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = PAIR_N1_S1;
      end
      S_RD4: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = PAIR_S2;
      end
      S_ACC: begin
      end
      S_MUL: cmd_o.mul_en = 1'b1;
      S_DIV: cmd_o.div_en = 1'b1;
      S_WB:  cmd_o.wb_en  = status_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/wave_stencil_fd4_periodic.sv
// Top level of the fourth-order periodic wave stencil.
// Depends on wsf4_pkg, wsf4_ctrl, wsf4_datapath and wsf4_grid_ram.
//
// The block keeps a previous and a current pressure grid of GRID_SIZE by
// GRID_SIZE signed Q2.16 samples in two memories with one write and two
// read ports each. A load item is written in the load state before the
// block returns to idle; an advance item (or the unused code) completes in
// its transfer cycle. A compute item runs from its transfer through the tap
// reads, since the nine taps of the current grid share its two read ports,
// then accumulates the last pair, does the coefficient multiply and the
// division by 12 * 2^24, and last saturates, writes back and loads the
// output register. The result sits in that register while the next item
// is taken; write-back waits only if the previous result has not yet left.
// The grids need no clearing after reset, so the block is ready at once;
// points must be loaded before use.
module wave_stencil_fd4_periodic #(
  parameter int unsigned GRID_SIZE = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // Fields from bit 0 up: col, row, old_value, curr_value, zero fill.
  input  logic [wsf4_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: op.
  input  logic [wsf4_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // Fields from bit 0 up: new_value, out_col, out_row.
  output logic [wsf4_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wsf4_pkg::COEFF_W-1:0]     cfg_data_i
);
  import wsf4_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The coefficient register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  wsf4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wsf4_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule

// File: hw/rtl/wsf4_checker.sv
// Port-level checks of the wave stencil top level, attached by bind.
// Depends on wsf4_pkg and wave_stencil_fd4_periodic_macros.svh.
`include "wave_stencil_fd4_periodic_macros.svh"

module wsf4_checker #(
  parameter int unsigned GRID_SIZE = 128
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [wsf4_pkg::OP_W-1:0]        s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [wsf4_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import wsf4_pkg::*;

  logic               in_xfer;
  logic               busy_op;
  logic               out_stall;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               coord_ok;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign busy_op   = (s_axis_tuser_i == OP_LOAD) || (s_axis_tuser_i == OP_COMPUTE);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_col   = m_axis_tdata_o[SAMPLE_W +: COORD_W];
  assign out_row   = m_axis_tdata_o[SAMPLE_W+COORD_W +: COORD_W];
  assign coord_ok  = (out_col < GRID_SIZE) && (out_row < GRID_SIZE);

  `WSF4_ASSERT_NEXT(a_out_valid_hold, out_stall, m_axis_tvalid_o, "result withdrawn while stalled")

  `WSF4_ASSERT_NEXT(a_out_data_hold, out_stall, $stable(m_axis_tdata_o), "result changed while stalled")

  `WSF4_ASSERT_NEXT(a_busy_after_work, in_xfer && busy_op, !s_axis_tready_o, "ready after a busy transfer")

  `WSF4_ASSERT_NEXT(a_ready_after_swap, in_xfer && !busy_op, s_axis_tready_o, "not ready after an advance")

  `WSF4_ASSERT(a_out_coord_range, !m_axis_tvalid_o || coord_ok, "reported coordinate outside the grid")

endmodule

bind wave_stencil_fd4_periodic wsf4_checker #(
  .GRID_SIZE (GRID_SIZE)
) u_wsf4_checker (.*);

// File: sim/wave_stencil_checker.sv
// Scoreboard for the fourth-order periodic wave stencil: watches the input, output
// and coefficient channels, keeps its own copy of both pressure grids and checks
// every output transfer. Depends on wsf4_pkg.
module wave_stencil_checker #(
  parameter int unsigned GRID_SIZE = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [wsf4_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic [wsf4_pkg::OP_W-1:0]        in_user_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [wsf4_pkg::OUT_TDATA_W-1:0] out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [wsf4_pkg::COEFF_W-1:0]     cfg_data_i,
  output int unsigned                      outstanding_o,
  output int unsigned                      mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsf4_pkg::*;

  localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE;
  localparam int TAP_WEIGHT [5] = '{-1, 16, -30, 16, -1};
  // The weights are twelve times the true Laplacian and the coefficient is Q0.24.
  localparam longint LAP_DIVISOR = longint'(12) * (longint'(1) << 24);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [COORD_W-1:0]         col;
    logic [COORD_W-1:0]         row;
  } point_result_t;

  logic signed [SAMPLE_W-1:0] pressure [2][CELLS];
  logic                       cur_sel;
  logic [COEFF_W-1:0]         step_coeff;
  point_result_t              next_level_q [$];
  int unsigned                pending_n;
  int unsigned                fail_total;

  assign outstanding_o = pending_n;
  assign mismatches_o  = fail_total;

  function automatic int wrap_coord(input int c, input int k);
    return (c + k + GRID_SIZE) % GRID_SIZE;
  endfunction

  function automatic int cell_of(input int c, input int r);
    return r * GRID_SIZE + c;
  endfunction

  // Applies one accepted item to the grid copy and queues the point it produces.
  function automatic void step_grids(input logic [IN_TDATA_W-1:0] beat,
                                     input logic [OP_W-1:0] op_bits);
    int                         c;
    int                         r;
    int                         center;
    longint                     lap12;
    longint                     incr;
    longint                     nv;
    point_result_t              res;
    logic signed [SAMPLE_W-1:0] old_v;
    logic signed [SAMPLE_W-1:0] curr_v;
    c      = int'(beat[COORD_W-1:0]) % GRID_SIZE;
    r      = int'(beat[COORD_W +: COORD_W]) % GRID_SIZE;
    old_v  = beat[2*COORD_W +: SAMPLE_W];
    curr_v = beat[2*COORD_W+SAMPLE_W +: SAMPLE_W];
    center = cell_of(c, r);
    case (op_bits)
      OP_LOAD: begin
        pressure[~cur_sel][center] = old_v;
        pressure[cur_sel][center]  = curr_v;
      end
      OP_ADVANCE: begin
        cur_sel = ~cur_sel;
      end
      OP_COMPUTE: begin
        lap12 = 0;
        for (int k = -2; k <= 2; k++) begin
          lap12 += longint'(TAP_WEIGHT[k+2])
                 * longint'(pressure[cur_sel][cell_of(wrap_coord(c, k), r)]);
          lap12 += longint'(TAP_WEIGHT[k+2])
                 * longint'(pressure[cur_sel][cell_of(c, wrap_coord(r, k))]);
        end
        // Signed division truncates toward zero.
        incr = (longint'(step_coeff) * lap12) / LAP_DIVISOR;
        nv = 2 * longint'(pressure[cur_sel][center]) - longint'(pressure[~cur_sel][center])
           + incr;
        if (nv > longint'(SAMPLE_MAX)) nv = longint'(SAMPLE_MAX);
        if (nv < longint'(SAMPLE_MIN)) nv = longint'(SAMPLE_MIN);
        pressure[~cur_sel][center] = nv[SAMPLE_W-1:0];
        res.value = nv[SAMPLE_W-1:0];
        res.col   = COORD_W'(c);
        res.row   = COORD_W'(r);
        next_level_q.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_point(input logic [OUT_TDATA_W-1:0] beat);
    point_result_t              want;
    logic signed [SAMPLE_W-1:0] got_value;
    logic [COORD_W-1:0]         got_col;
    logic [COORD_W-1:0]         got_row;
    got_value = beat[SAMPLE_W-1:0];
    got_col   = beat[SAMPLE_W +: COORD_W];
    got_row   = beat[SAMPLE_W+COORD_W +: COORD_W];
    if (next_level_q.size() == 0) begin
      $display("%0t: unexpected output transfer: value %0d at col %0d row %0d",
               $time, got_value, got_col, got_row);
      fail_total++;
      return;
    end
    want = next_level_q.pop_front();
    if (got_value !== want.value) begin
      $display("%0t: new_value mismatch: expected %0d, actual %0d", $time, want.value,
               got_value);
      fail_total++;
    end
    if (got_col !== want.col) begin
      $display("%0t: out_col mismatch: expected %0d, actual %0d", $time, want.col, got_col);
      fail_total++;
    end
    if (got_row !== want.row) begin
      $display("%0t: out_row mismatch: expected %0d, actual %0d", $time, want.row, got_row);
      fail_total++;
    end
  endfunction

  initial fail_total = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_sel    = 1'b0;
      step_coeff = '0;
      next_level_q.delete();
      pending_n <= 0;
    end else begin
      // A result leaving now always belongs to an older compute, so check first.
      if (out_valid_i && out_ready_i) check_point(out_data_i);
      if (cfg_valid_i && cfg_ready_i) step_coeff = cfg_data_i;
      if (in_valid_i && in_ready_i) step_grids(in_data_i, in_user_i);
      pending_n <= next_level_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the wave stencil testbench: clock, reset, stimulus and verdict.
// Depends on wsf4_pkg, wave_stencil_fd4_periodic and wave_stencil_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wsf4_pkg::*;

  localparam int GRID_SIZE        = 128;
  localparam int SETTLE_CYCLES    = 16;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 380;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SRC_IDLE_PCT [4]   = '{0, 59, 0, 32};
  localparam int SINK_STALL_PCT [4] = '{0, 0, 59, 32};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COEFF_W-1:0]     cfg_data = '0;
  int unsigned            outstanding;
  int unsigned            mismatches;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  bit cell_loaded [GRID_SIZE*GRID_SIZE];
  int target_c;
  int target_r;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wave_stencil_fd4_periodic #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  wave_stencil_checker #(
    .GRID_SIZE(GRID_SIZE)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .in_user_i    (s_tuser),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  function automatic int wrap_coord(input int c, input int k);
    return (c + k + GRID_SIZE) % GRID_SIZE;
  endfunction

  // Mostly small values so the update stays in range, with full-range values
  // and the two extremes mixed in.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic offer_item(input logic [OP_W-1:0] op, input int c, input int r,
                            input logic signed [SAMPLE_W-1:0] ov,
                            input logic signed [SAMPLE_W-1:0] cv);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({cv, ov, COORD_W'(r), COORD_W'(c)});
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_value(input int c, input int r, input logic signed [SAMPLE_W-1:0] ov,
                            input logic signed [SAMPLE_W-1:0] cv);
    offer_item(OP_LOAD, c, r, ov, cv);
    cell_loaded[r*GRID_SIZE + c] = 1'b1;
  endtask

  // Computes the point if all nine taps hold data, otherwise loads a missing tap.
  task automatic compute_or_fill(input int c, input int r);
    int miss_c;
    int miss_r;
    miss_c = -1;
    miss_r = -1;
    for (int k = -2; k <= 2; k++) begin
      if (!cell_loaded[r*GRID_SIZE + wrap_coord(c, k)]) begin
        miss_c = wrap_coord(c, k);
        miss_r = r;
      end
      if (!cell_loaded[wrap_coord(r, k)*GRID_SIZE + c]) begin
        miss_c = c;
        miss_r = wrap_coord(r, k);
      end
    end
    if (miss_c < 0) begin
      offer_item(OP_COMPUTE, c, r, random_sample(), random_sample());
      if (c == target_c && r == target_r) begin
        target_c = $urandom_range(0, GRID_SIZE - 1);
        target_r = $urandom_range(0, GRID_SIZE - 1);
      end
    end else begin
      load_value(miss_c, miss_r, random_sample(), random_sample());
    end
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      offer_item(OP_ADVANCE, $urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1),
                 random_sample(), random_sample());
    end else if (pick < 11) begin
      offer_item(OP_UNUSED, $urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1),
                 random_sample(), random_sample());
    end else if (pick < 45) begin
      // Loads land mostly in a window that straddles the wrap-around edges.
      if ($urandom_range(0, 3) == 0) begin
        load_value($urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1),
                   random_sample(), random_sample());
      end else begin
        load_value((124 + $urandom_range(0, 9)) % GRID_SIZE,
                   (124 + $urandom_range(0, 9)) % GRID_SIZE, random_sample(), random_sample());
      end
    end else if ($urandom_range(0, 4) == 0) begin
      compute_or_fill(target_c, target_r);
    end else begin
      compute_or_fill((126 + $urandom_range(0, 5)) % GRID_SIZE,
                      (126 + $urandom_range(0, 5)) % GRID_SIZE);
    end
  endtask

  // Loads and advances produce nothing, so the block gets a settling wait
  // after the last result before the coefficient changes.
  task automatic write_step_coeff(input logic [COEFF_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    target_c = $urandom_range(0, GRID_SIZE - 1);
    target_r = $urandom_range(0, GRID_SIZE - 1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cross of taps around the origin, so the west and north neighbors wrap across the edges.
    for (int k = -2; k <= 2; k++) begin
      load_value(wrap_coord(0, k), 0, SAMPLE_MIN, SAMPLE_MAX);
      if (k != 0) load_value(0, wrap_coord(0, k), SAMPLE_MIN, SAMPLE_MAX);
    end
    // Zero coefficient: 2*max - min saturates high.
    offer_item(OP_COMPUTE, 0, 0, '0, '0);
    offer_item(OP_UNUSED, GRID_SIZE - 1, GRID_SIZE - 1, '1, '1);
    offer_item(OP_ADVANCE, 0, 0, '0, '0);
    write_step_coeff('1);
    // Largest coefficient with opposite extremes on the taps: saturates low,
    // then high once the grids swap back.
    offer_item(OP_COMPUTE, 0, 0, '0, '0);
    offer_item(OP_ADVANCE, 0, 0, '0, '0);
    offer_item(OP_COMPUTE, 0, 0, '0, '0);
    load_value(0, 0, '0, '0);
    offer_item(OP_COMPUTE, 0, 0, '0, '0);

    // Output held off while computes keep coming, so the input side backs up.
    hold_req = 1'b1;
    repeat (10) offer_item(OP_COMPUTE, 0, 0, random_sample(), random_sample());

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_step_coeff(COEFF_W'($urandom));
        1: write_step_coeff('0);
        2: write_step_coeff(COEFF_W'($urandom_range(24'h100000, 24'h800000)));
        default: write_step_coeff('1);
      endcase
      src_idle_pct   = SRC_IDLE_PCT[ph];
      sink_stall_pct = SINK_STALL_PCT[ph];
      repeat (RANDOM_PER_PHASE) random_item();
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/wsf4_pkg.sv
hw/rtl/wsf4_grid_ram.sv
hw/rtl/wsf4_datapath.sv
hw/rtl/wsf4_ctrl.sv
hw/rtl/wave_stencil_fd4_periodic.sv
hw/rtl/wsf4_checker.sv
sim/wave_stencil_checker.sv
sim/testbench.sv
